### design/rational_arithmetic_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rational arithmetic unit
// Concurrent property wrappers that compile away with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RAU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define RAU_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define RAU_ASSERT(label, clk, rst_n, prop)
`define RAU_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### design/rau_pkg.sv
// ---------------------------------------------------------------------------
// Rational arithmetic unit package
// Command codes, payload structs and controller/datapath interface types.
// ---------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned OperandWidth = 16;
  localparam int unsigned ResNumWidth  = 32;
  localparam int unsigned ResDenWidth  = 31;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_CMP = 3'd4,
    CMD_NEG = 3'd5
  } cmd_e;

  // input request payload
  typedef struct packed {
    logic [2:0]                     command;
    logic signed [OperandWidth-1:0] first_numerator;
    logic [OperandWidth-2:0]        first_denominator;
    logic signed [OperandWidth-1:0] second_numerator;
    logic [OperandWidth-2:0]        second_denominator;
  } rau_req_t;

  // result payload
  typedef struct packed {
    logic signed [ResNumWidth-1:0] result_numerator;
    logic [ResDenWidth-1:0]        result_denominator;
    logic                          less_than;
    logic                          equal_to;
    logic                          greater_than;
    logic                          divide_error;
  } rau_res_t;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,  // capture request, form cross products
    OP_PREP  = 3'd2,  // form magnitudes / flags
    OP_GSTEP = 3'd3,  // one remainder bit of gcd
    OP_GSWAP = 3'd4,  // end of one gcd remainder
    OP_QINIT = 3'd5,  // start quotient divisions
    OP_QSTEP = 3'd6,  // one quotient bit
    OP_FIN   = 3'd7   // build result
  } op_e;

  typedef struct packed {
    op_e  op;
    logic qsel;       // 0 numerator, 1 denominator division
  } dp_cmd_t;

  typedef struct packed {
    logic direct;     // result ready after prep, no gcd
    logic gcd_done;   // remainder divisor is zero
  } dp_sts_t;

endpackage

### design/rational_arithmetic_unit.sv
// Flow: compare, negate, errors and zero results go from load through prep
//   and check straight to the output; otherwise the gcd remainder loops and
//   the two quotient divisions run before the result is shown.
// Throughput: one request at a time; the next is taken only once the result
//   has been taken; the bit-serial remainder unit sets the rate.
// Reset: rst_ni async low clears the controller; datapath needs no reset.
// ---------------------------------------------------------------------------
// Rational arithmetic unit
// Fraction add/sub/mul/div with gcd reduction, compare and negate.
// ---------------------------------------------------------------------------
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rau_req_t req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rau_res_t res_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // controller: one request in flight, result held until taken
  rau_ctrl #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(dp_cmd), .sts_i(dp_sts)
  );

  // datapath: cross products, Euclid by restoring remainders, quotients
  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk_i, .command_i(req_i.command),
    .n1_i(req_i.first_numerator), .d1_i(req_i.first_denominator),
    .n2_i(req_i.second_numerator), .d2_i(req_i.second_denominator),
    .cmd_i(dp_cmd), .sts_o(dp_sts),
    .res_num_o(res_o.result_numerator), .res_den_o(res_o.result_denominator),
    .lt_o(res_o.less_than), .eq_o(res_o.equal_to), .gt_o(res_o.greater_than),
    .err_o(res_o.divide_error)
  );

  // no new request while a result waits
  `RAU_ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, in_ready_o && out_valid_o)
  // compare flags are mutually exclusive
  `RAU_ASSERT(a_flags, clk_i, rst_ni,
    out_valid_o |-> $countones({res_o.less_than, res_o.equal_to, res_o.greater_than}) <= 1)
  // a valid result has a nonzero denominator
  `RAU_ASSERT(a_den, clk_i, rst_ni,
    (out_valid_o && !res_o.divide_error && !res_o.less_than && !res_o.equal_to &&
     !res_o.greater_than) |-> res_o.result_denominator != '0)

endmodule

### design/rau_datapath.sv
// ---------------------------------------------------------------------------
// Rational arithmetic datapath
// Cross products, bit-serial Euclid gcd and restoring quotient divisions.
// ---------------------------------------------------------------------------
module rau_datapath import rau_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidth
) (
  input  logic                     clk_i,
  input  logic [2:0]               command_i,
  input  logic signed [OPERAND_WIDTH-1:0] n1_i,
  input  logic [OPERAND_WIDTH-2:0] d1_i,
  input  logic signed [OPERAND_WIDTH-1:0] n2_i,
  input  logic [OPERAND_WIDTH-2:0] d2_i,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  output logic [ResNumWidth-1:0]   res_num_o,
  output logic [ResDenWidth-1:0]   res_den_o,
  output logic                     lt_o,
  output logic                     eq_o,
  output logic                     gt_o,
  output logic                     err_o
);

  localparam int unsigned PW = 2 * OPERAND_WIDTH;     // product width, signed
  localparam int unsigned MW = PW + 1;                // magnitude width
  localparam int unsigned CW = $clog2(MW + 1);

  logic [2:0]           cmd_q;
  logic signed [PW-1:0] pa_q, pb_q, pd_q;
  logic                 bad_q, dz_q;
  logic signed [OPERAND_WIDTH-1:0] n1_q;
  logic [OPERAND_WIDTH-2:0] d1_q;
  logic signed [PW:0]   num_q, den_q;
  logic [MW-1:0]        nm_q, dm_q, ga_q, gb_q, rem_q, quo_q, sh_q;
  logic [CW-1:0]        cnt_q;
  logic                 neg_q, direct_q;
  logic [ResNumWidth-1:0] res_num_q;
  logic [ResDenWidth-1:0] res_den_q;
  logic lt_q, eq_q, gt_q, err_q;

  logic [MW:0] trial;
  logic [MW-1:0] divisor;
  assign divisor = ga_q;  // final gcd sits in ga
  assign trial = {rem_q, sh_q[MW-1]} - {1'b0, (cmd_i.op == OP_GSTEP) ? gb_q : divisor};

  assign sts_o.direct   = direct_q;
  assign sts_o.gcd_done = (gb_q == '0);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cmd_q <= command_i;
        n1_q  <= n1_i;
        d1_q  <= d1_i;
        pa_q  <= PW'(n1_i * $signed({1'b0, d2_i}));
        pb_q  <= PW'(n2_i * $signed({1'b0, d1_i}));
        pd_q  <= PW'($signed({1'b0, d1_i}) * $signed({1'b0, d2_i}));
        bad_q <= (d1_i == '0) || (command_i != CMD_NEG && d2_i == '0);
        dz_q  <= (n2_i == '0);
        case (command_i)
          CMD_MUL: num_q <= (PW+1)'(n1_i * n2_i);
          CMD_DIV: num_q <= '0;
          default: num_q <= '0;
        endcase
        den_q <= (PW+1)'($signed({1'b0, d1_i}) * n2_i);
      end
      OP_PREP: begin
        lt_q <= 1'b0; eq_q <= 1'b0; gt_q <= 1'b0; err_q <= 1'b0;
        res_num_q <= '0; res_den_q <= ResDenWidth'(1);
        direct_q <= 1'b1;
        if (cmd_q > CMD_NEG) begin
        end else if (bad_q) begin
          err_q <= 1'b1;
        end else begin
          case (cmd_q)
            CMD_CMP: begin
              lt_q <= pa_q < pb_q; eq_q <= pa_q == pb_q; gt_q <= pa_q > pb_q;
            end
            CMD_NEG: begin
              res_num_q <= ResNumWidth'(-$signed({n1_q[OPERAND_WIDTH-1], n1_q}));
              res_den_q <= ResDenWidth'(d1_q);
            end
            CMD_DIV: begin
              if (dz_q) err_q <= 1'b1;
              else if (pa_q == '0) begin end
              else begin
                direct_q <= 1'b0;
                neg_q <= (pa_q < 0) != (den_q < 0);
                nm_q <= MW'(pa_q < 0 ? -$signed({pa_q[PW-1], pa_q}) : pa_q);
                dm_q <= MW'(den_q < 0 ? -den_q : den_q);
                ga_q <= MW'(pa_q < 0 ? -$signed({pa_q[PW-1], pa_q}) : pa_q);
                gb_q <= MW'(den_q < 0 ? -den_q : den_q);
              end
            end
            default: begin
              logic signed [PW:0] s;
              s = (cmd_q == CMD_ADD) ? ($signed({pa_q[PW-1], pa_q}) + pb_q) :
                  (cmd_q == CMD_SUB) ? ($signed({pa_q[PW-1], pa_q}) - pb_q) :
                  num_q;
              if (s != '0) begin
                direct_q <= 1'b0;
                neg_q <= s < 0;
                nm_q <= MW'(s < 0 ? -s : s);
                ga_q <= MW'(s < 0 ? -s : s);
                dm_q <= MW'(pd_q);
                gb_q <= MW'(pd_q);
              end
            end
          endcase
        end
        cnt_q <= '0; rem_q <= '0; sh_q <= '0;
      end
      OP_GSTEP: begin
        // first step of a remainder loads the dividend
        if (cnt_q == '0 && rem_q == '0 && sh_q == '0) begin
          sh_q <= ga_q; cnt_q <= CW'(1);
        end else begin
          if (!trial[MW]) rem_q <= trial[MW-1:0];
          else rem_q <= {rem_q[MW-2:0], sh_q[MW-1]};
          sh_q <= {sh_q[MW-2:0], 1'b0};
          cnt_q <= cnt_q + CW'(1);
        end
      end
      OP_GSWAP: begin
        ga_q <= gb_q; gb_q <= rem_q;
        cnt_q <= '0; rem_q <= '0; sh_q <= '0;
      end
      OP_QINIT: begin
        sh_q <= cmd_i.qsel ? dm_q : nm_q;
        rem_q <= '0; quo_q <= '0; cnt_q <= '0;
      end
      OP_QSTEP: begin
        if (!trial[MW]) rem_q <= trial[MW-1:0];
        else rem_q <= {rem_q[MW-2:0], sh_q[MW-1]};
        quo_q <= {quo_q[MW-2:0], ~trial[MW]};
        sh_q <= {sh_q[MW-2:0], 1'b0};
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(MW - 1)) begin
          if (cmd_i.qsel) res_den_q <= ResDenWidth'({quo_q[MW-2:0], ~trial[MW]});
          else res_num_q <= ResNumWidth'(neg_q ? -{quo_q[MW-2:0], ~trial[MW]}
                                              : {quo_q[MW-2:0], ~trial[MW]});
        end
      end
      default: begin
      end
    endcase
  end

  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign lt_o = lt_q;
  assign eq_o = eq_q;
  assign gt_o = gt_q;
  assign err_o = err_q;

endmodule

### design/rau_ctrl.sv
// ---------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences load, gcd remainder loops, two quotient divisions and output.
// ---------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  localparam int unsigned MW = 2 * OPERAND_WIDTH + 1;
  localparam int unsigned CW = $clog2(MW + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_CHK, S_GCD, S_QNUM, S_QDEN, S_OUT
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q;
  logic          out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '{op: OP_NONE, qsel: 1'b0};
    case (state_q)
      S_IDLE: if (in_valid_i && !out_valid_q) cmd_o.op = OP_LOAD;
      S_PREP: cmd_o.op = OP_PREP;
      S_CHK: begin
        if (!sts_i.direct) cmd_o.op = sts_i.gcd_done ? OP_QINIT : OP_GSTEP;
      end
      S_GCD:  cmd_o.op = (cnt_q == CW'(MW + 1)) ? OP_GSWAP : OP_GSTEP;
      S_QNUM: begin
        cmd_o.op = (cnt_q == CW'(MW)) ? OP_QINIT : OP_QSTEP;
        cmd_o.qsel = (cnt_q == CW'(MW));
      end
      S_QDEN: begin
        cmd_o.op = OP_QSTEP; cmd_o.qsel = 1'b1;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i && !out_valid_q) state_q <= S_PREP;
        S_PREP: state_q <= S_CHK;
        S_CHK: begin
          cnt_q <= '0;
          if (sts_i.direct) begin
            out_valid_q <= 1'b1; state_q <= S_IDLE;
          end else if (sts_i.gcd_done) state_q <= S_QNUM;
          else begin
            state_q <= S_GCD; cnt_q <= CW'(1);
          end
        end
        S_GCD: begin
          if (cnt_q == CW'(MW + 1)) begin
            cnt_q <= '0; state_q <= S_CHK;
          end else cnt_q <= cnt_q + CW'(1);
        end
        S_QNUM: begin
          if (cnt_q == CW'(MW)) begin
            cnt_q <= '0; state_q <= S_QDEN;
          end else cnt_q <= cnt_q + CW'(1);
        end
        S_QDEN: begin
          if (cnt_q == CW'(MW - 1)) begin
            cnt_q <= '0; state_q <= S_OUT;
          end else cnt_q <= cnt_q + CW'(1);
        end
        S_OUT: begin
          out_valid_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Sends fraction requests through the valid/ready input and predicts each
// reduced result, compare flag set and error flag in a scoreboard. Output
// results are checked in order. The run has four idle/stall phases and a
// long output hold-off that backs up the input.
// ---------------------------------------------------------------------------
import rau_pkg::*;

class frac_scoreboard;
  rau_res_t pending[$];
  int       mismatches;
  int       checked;
  int       unexpected;

  // reduce num/den by gcd of magnitudes; den nonzero
  function automatic rau_res_t reduce(longint num, longint den);
    rau_res_t r;
    longint   a, b, t;
    bit       neg;
    r = '0;
    r.result_denominator = 31'd1;
    if (num == 0) return r;
    neg = (num < 0) != (den < 0);
    a = (num < 0) ? -num : num;
    b = (den < 0) ? -den : den;
    begin
      longint x, y;
      x = a;
      y = b;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      a = a / x;
      b = b / x;
    end
    r.result_numerator = 32'(neg ? -a : a);
    r.result_denominator = 31'(b);
    return r;
  endfunction

  function automatic rau_res_t predict(rau_req_t q);
    rau_res_t r;
    longint   n1, d1, n2, d2, lhs, rhs;
    n1 = longint'($signed(q.first_numerator));
    n2 = longint'($signed(q.second_numerator));
    d1 = longint'(q.first_denominator);
    d2 = longint'(q.second_denominator);
    r = '0;
    r.result_denominator = 31'd1;
    if (q.command > CMD_NEG) return r;
    if (d1 == 0 || (q.command != CMD_NEG && d2 == 0)) begin
      r.divide_error = 1'b1;
      return r;
    end
    case (q.command)
      CMD_ADD: r = reduce(n1 * d2 + n2 * d1, d1 * d2);
      CMD_SUB: r = reduce(n1 * d2 - n2 * d1, d1 * d2);
      CMD_MUL: r = reduce(n1 * n2, d1 * d2);
      CMD_DIV: begin
        if (n2 == 0) r.divide_error = 1'b1;
        else r = reduce(n1 * d2, d1 * n2);
      end
      CMD_CMP: begin
        lhs = n1 * d2;
        rhs = n2 * d1;
        r.less_than = lhs < rhs;
        r.equal_to = lhs == rhs;
        r.greater_than = lhs > rhs;
      end
      default: begin
        // negate: not reduced
        r.result_numerator = 32'(-n1);
        r.result_denominator = 31'(d1);
      end
    endcase
    return r;
  endfunction

  function void note_request(rau_req_t q);
    pending.push_back(predict(q));
  endfunction

  function void check_result(rau_res_t got);
    rau_res_t want;
    checked++;
    if (pending.size() == 0) begin
      unexpected++;
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: exp num=%0d den=%0d lt%b eq%b gt%b err%b",
                 want.result_numerator, want.result_denominator, want.less_than,
                 want.equal_to, want.greater_than, want.divide_error);
        $display("          got num=%0d den=%0d lt%b eq%b gt%b err%b",
                 got.result_numerator, got.result_denominator, got.less_than,
                 got.equal_to, got.greater_than, got.divide_error);
      end
    end
  endfunction
endclass

module testbench;
  localparam int StallLimit = 20000;
  localparam int HoldCycles = 600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  rau_req_t    req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rau_res_t    res;

  frac_scoreboard sb = new();

  int  send_idle_pct = 0;   // sender gap chance, percent
  int  recv_stall_pct = 0;  // receiver stall chance, percent
  logic hold_req = 1'b0;
  bit  hold_seen = 1'b0;    // long hold-off runs once
  int  hold_left = 0;
  int  quiet_cycles = 0;
  int  sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rational_arithmetic_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_i       (req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .res_o       (res)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_seen) begin
      out_ready <= 1'b0;
      hold_seen <= 1'b1;
      hold_left <= HoldCycles;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: both handshakes, plus the no-progress watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(req);
      if (out_valid && out_ready) sb.check_result(res);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", StallLimit);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // offer one request and wait for it to be taken
  task automatic send_request(input logic [2:0] cmd, input logic [15:0] n1,
                              input logic [14:0] d1, input logic [15:0] n2,
                              input logic [14:0] d2);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    req <= '{cmd, n1, d1, n2, d2};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [14:0] pick_den();
    case ($urandom_range(9))
      0: return 15'd0;
      1: return 15'd1;
      2: return 15'h7fff;
      3: return 15'($urandom_range(12));
      default: return 15'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_num();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'($signed($urandom_range(24)) - 12);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic [2:0]  cmd;
    logic [15:0] n1, n2;
    logic [14:0] d1, d2;
    cmd = ($urandom_range(49) == 0) ? 3'($urandom_range(7, 6))
                                    : 3'($urandom_range(5));
    n1 = pick_num();
    n2 = pick_num();
    d1 = pick_den();
    d2 = pick_den();
    // equal-valued pair now and then, to hit the equal flag and full cancels
    if ($urandom_range(7) == 0) begin
      n2 = n1;
      d2 = d1;
    end
    send_request(cmd, n1, d1, n2, d2);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every command, special cases
    send_request(CMD_ADD, 16'h7fff, 15'h7fff, 16'h7fff, 15'h7fff);
    send_request(CMD_ADD, 16'h8000, 15'd1, 16'h8000, 15'd1);
    send_request(CMD_SUB, 16'd3, 15'd4, 16'd3, 15'd4);           // zero result
    send_request(CMD_SUB, 16'h8000, 15'h7fff, 16'h7fff, 15'd1);
    send_request(CMD_MUL, 16'h8000, 15'd1, 16'h8000, 15'd1);
    send_request(CMD_MUL, 16'd6, 15'd10, 16'hfff1, 15'd4);
    send_request(CMD_MUL, 16'd0, 15'd5, 16'd7, 15'd3);
    send_request(CMD_DIV, 16'd1, 15'd2, 16'hfffd, 15'd4);        // negative divisor
    send_request(CMD_DIV, 16'd5, 15'd7, 16'd0, 15'd9);           // zero fraction
    send_request(CMD_DIV, 16'h8000, 15'd1, 16'hffff, 15'h7fff);
    send_request(CMD_CMP, 16'd1, 15'd2, 16'd2, 15'd4);
    send_request(CMD_CMP, 16'hffff, 15'd3, 16'd1, 15'd3);
    send_request(CMD_CMP, 16'h7fff, 15'd1, 16'h8000, 15'd1);
    send_request(CMD_NEG, 16'h8000, 15'd6, 16'd0, 15'd0);        // second unused
    send_request(CMD_NEG, 16'd4, 15'h7fff, 16'd1, 15'd1);
    send_request(CMD_ADD, 16'd1, 15'd0, 16'd1, 15'd1);           // zero first den
    send_request(CMD_CMP, 16'd1, 15'd1, 16'd1, 15'd0);           // zero second den
    send_request(CMD_NEG, 16'd9, 15'd0, 16'd1, 15'd1);
    send_request(3'd6, 16'd1, 15'd1, 16'd1, 15'd1);
    send_request(3'd7, 16'hffff, 15'h7fff, 16'hffff, 15'h7fff);
    send_request(CMD_ADD, 16'd17711, 15'd28657, 16'd0, 15'd1);  // long gcd chain
    drain();

    // random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 82 : (ph == 3) ? 35 : 0;
      recv_stall_pct = (ph == 2) ? 82 : (ph == 3) ? 35 : 0;
      if (ph == 0) hold_req <= 1'b1;  // back up the block early on
      for (int k = 0; k < 195; k++) begin
        if (k == 2) hold_req <= 1'b0;
        send_random();
      end
      drain();
    end

    $display("covered %0d requests over 4 idle/stall phases, %0d results checked",
             sent, sb.checked);
    $display("%0d mismatches, %0d unexpected results", sb.mismatches, sb.unexpected);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+design
design/rau_pkg.sv
design/rau_datapath.sv
design/rau_ctrl.sv
design/rational_arithmetic_unit.sv
verif/testbench.sv
